FILE: rtl/icph_pkg.sv
// Shared types and constants for the internet checksum pseudo-header unit.
package icph_pkg;

    // Field and datapath widths
    localparam int DATA_W    = 16;
    localparam int COUNT_W   = 2;
    localparam int SUM_W     = 32;
    localparam int BYTES_W   = 16;
    localparam int BASE_W    = 19;   // start value plus four address halves plus protocol
    localparam int TOTAL_W   = 33;
    localparam int APB_AW    = 5;
    localparam int APB_DW    = 32;
    localparam int ADDR_W    = 32;
    localparam int PROTO_W   = 8;

    // Byte count codes of one word
    localparam logic [COUNT_W-1:0] BYTES_NONE = 2'd0;
    localparam logic [COUNT_W-1:0] BYTES_ONE  = 2'd1;
    localparam logic [COUNT_W-1:0] BYTES_TWO  = 2'd2;
    localparam logic [COUNT_W-1:0] BYTES_WIDE = 2'd3;

    // A one-byte word keeps only its first byte
    localparam logic [DATA_W-1:0] HIGH_BYTE_MASK = 16'hFF00;

    // Register map, word index into the APB space
    typedef enum logic [2:0] {
        REG_PSEUDO_ENABLE = 3'd0,
        REG_SRC_ADDR      = 3'd1,
        REG_DST_ADDR      = 3'd2,
        REG_PROTOCOL      = 3'd3,
        REG_INITIAL_SUM   = 3'd4
    } t_reg_idx;

    // End-of-packet accumulator snapshot
    typedef struct packed {
        logic [SUM_W-1:0]   sum;
        logic [BYTES_W-1:0] bytes;
    } t_pkt_end;

    // Settings seen by the final sum stage
    typedef struct packed {
        logic              pseudo_enable;
        logic [BASE_W-1:0] base_sum;
    } t_cfg;

endpackage

FILE: rtl/icph_in_if.sv
// Input word channel: valid/ready with one packet word.
interface icph_in_if;
    logic                           valid;
    logic                           ready;
    logic [icph_pkg::DATA_W-1:0]    data_word;
    logic [icph_pkg::COUNT_W-1:0]   byte_count;
    logic                           last;

    modport source (output valid, output data_word, output byte_count, output last,
                    input ready);
    modport sink   (input valid, input data_word, input byte_count, input last,
                    output ready);
endinterface

FILE: rtl/icph_out_if.sv
// Result channel: valid/ready with one checksum word.
interface icph_out_if;
    logic                           valid;
    logic                           ready;
    logic [icph_pkg::DATA_W-1:0]    checksum_value;

    modport source (output valid, output checksum_value, input ready);
    modport sink   (input valid, input checksum_value, output ready);
endinterface

FILE: rtl/icph_cfg.sv
// APB register file and precomputed pseudo-header base sum.
module icph_cfg (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [icph_pkg::APB_AW-1:0]     paddr,
    input  logic [icph_pkg::APB_DW-1:0]     pwdata,
    output logic [icph_pkg::APB_DW-1:0]     prdata,
    output logic                            pready,
    output icph_pkg::t_cfg                  o_cfg
);

    logic                               r_pseudo_enable;
    logic [icph_pkg::ADDR_W-1:0]        r_src_addr;
    logic [icph_pkg::ADDR_W-1:0]        r_dst_addr;
    logic [icph_pkg::PROTO_W-1:0]       r_protocol;
    logic [icph_pkg::DATA_W-1:0]        r_initial_sum;
    logic [icph_pkg::BASE_W-1:0]        r_base_sum;
    logic [icph_pkg::BASE_W-1:0]        n_base_sum;
    logic                               w_wr;
    icph_pkg::t_reg_idx                 w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = icph_pkg::t_reg_idx'(paddr[icph_pkg::APB_AW-1:2]);

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pseudo_enable <= 1'b0;
            r_src_addr      <= '0;
            r_dst_addr      <= '0;
            r_protocol      <= '0;
            r_initial_sum   <= '0;
        end else if (w_wr) begin
            case (w_idx)
                icph_pkg::REG_PSEUDO_ENABLE: r_pseudo_enable <= pwdata[0];
                icph_pkg::REG_SRC_ADDR:      r_src_addr      <= pwdata;
                icph_pkg::REG_DST_ADDR:      r_dst_addr      <= pwdata;
                icph_pkg::REG_PROTOCOL:      r_protocol      <= pwdata[icph_pkg::PROTO_W-1:0];
                icph_pkg::REG_INITIAL_SUM:   r_initial_sum   <= pwdata[icph_pkg::DATA_W-1:0];
                default: ;
            endcase
        end
    end

    // Read-back
    always_comb begin
        case (w_idx)
            icph_pkg::REG_PSEUDO_ENABLE: prdata = {31'd0, r_pseudo_enable};
            icph_pkg::REG_SRC_ADDR:      prdata = r_src_addr;
            icph_pkg::REG_DST_ADDR:      prdata = r_dst_addr;
            icph_pkg::REG_PROTOCOL:      prdata = {24'd0, r_protocol};
            icph_pkg::REG_INITIAL_SUM:   prdata = {16'd0, r_initial_sum};
            default:                     prdata = '0;
        endcase
    end

    // Start value plus the constant part of the pseudo-header
    always_comb begin
        n_base_sum = icph_pkg::BASE_W'(r_initial_sum);
        if (r_pseudo_enable) begin
            n_base_sum = n_base_sum
                       + icph_pkg::BASE_W'(r_src_addr[31:16])
                       + icph_pkg::BASE_W'(r_src_addr[15:0])
                       + icph_pkg::BASE_W'(r_dst_addr[31:16])
                       + icph_pkg::BASE_W'(r_dst_addr[15:0])
                       + icph_pkg::BASE_W'(r_protocol);
        end
    end

    always_ff @(posedge i_clk) begin
        r_base_sum <= n_base_sum;
    end

    assign o_cfg.pseudo_enable = r_pseudo_enable;
    assign o_cfg.base_sum      = r_base_sum;

endmodule

FILE: rtl/icph_acc.sv
// Input register and per-word end-around-carry accumulator.
module icph_acc (
    input  logic                i_clk,
    input  logic                i_rst_n,
    icph_in_if.sink             i_in,
    output logic                o_end_valid,
    input  logic                i_end_ready,
    output icph_pkg::t_pkt_end  o_end
);

    logic                                   r_i_valid;
    logic [icph_pkg::DATA_W-1:0]            r_i_word;
    logic [icph_pkg::COUNT_W-1:0]           r_i_count;
    logic                                   r_i_last;
    logic [icph_pkg::SUM_W-1:0]             r_sum;
    logic [icph_pkg::BYTES_W-1:0]           r_bytes;
    logic                                   r_e_valid;
    icph_pkg::t_pkt_end                     r_e;

    logic [icph_pkg::DATA_W-1:0]            w_addend;
    logic [1:0]                             w_inc;
    logic [icph_pkg::SUM_W:0]               w_sum_wide;
    logic [icph_pkg::SUM_W-1:0]             n_sum;
    logic [icph_pkg::BYTES_W-1:0]           n_bytes;
    logic                                   w_e_free;
    logic                                   w_i_move;
    logic                                   w_i_free;

    // Handshake: a non-last word only updates the accumulator, so it always moves on
    assign w_e_free   = !r_e_valid || i_end_ready;
    assign w_i_move   = r_i_valid && (!r_i_last || w_e_free);
    assign w_i_free   = !r_i_valid || w_i_move;
    assign i_in.ready = w_i_free;

    // Valid part of the word
    always_comb begin
        case (r_i_count)
            icph_pkg::BYTES_ONE: begin
                w_addend = r_i_word & icph_pkg::HIGH_BYTE_MASK;
                w_inc    = 2'd1;
            end
            icph_pkg::BYTES_TWO, icph_pkg::BYTES_WIDE: begin
                w_addend = r_i_word;
                w_inc    = 2'd2;
            end
            default: begin
                w_addend = '0;
                w_inc    = 2'd0;
            end
        endcase
    end

    // One's-complement add: carry out of bit 31 goes back into bit 0
    assign w_sum_wide = {1'b0, r_sum} + {17'd0, w_addend};
    assign n_sum      = w_sum_wide[icph_pkg::SUM_W-1:0]
                      + {31'd0, w_sum_wide[icph_pkg::SUM_W]};
    assign n_bytes    = r_bytes + {14'd0, w_inc};

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_i_valid <= 1'b0;
            r_sum     <= '0;
            r_bytes   <= '0;
            r_e_valid <= 1'b0;
        end else begin
            if (w_i_free)
                r_i_valid <= i_in.valid;
            if (w_i_move) begin
                if (r_i_last) begin
                    r_sum   <= '0;
                    r_bytes <= '0;
                end else begin
                    r_sum   <= n_sum;
                    r_bytes <= n_bytes;
                end
            end
            if (w_i_move && r_i_last)
                r_e_valid <= 1'b1;
            else if (i_end_ready)
                r_e_valid <= 1'b0;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (w_i_free) begin
            r_i_word  <= i_in.data_word;
            r_i_count <= i_in.byte_count;
            r_i_last  <= i_in.last;
        end
        if (w_i_move && r_i_last) begin
            r_e.sum   <= n_sum;
            r_e.bytes <= n_bytes;
        end
    end

    assign o_end_valid = r_e_valid;
    assign o_end       = r_e;

    // A finished packet leaves the accumulator clear
    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_i_move && r_i_last) |=> (r_sum == '0 && r_bytes == '0))
        else $error("accumulator not cleared after last word");

    // A held packet end is not lost while the next stage is busy
    a_end_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_e_valid && !i_end_ready) |=> (r_e_valid && $stable(r_e)))
        else $error("packet end overwritten while stalled");

endmodule

FILE: rtl/icph_fold.sv
// Final sum with pseudo-header, carry fold and complement into the output register.
module icph_fold (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_end_valid,
    output logic                o_end_ready,
    input  icph_pkg::t_pkt_end  i_end,
    input  icph_pkg::t_cfg      i_cfg,
    icph_out_if.source          o_out
);

    logic                                   r_t_valid;
    logic [icph_pkg::TOTAL_W-1:0]           r_total;
    logic                                   r_o_valid;
    logic [icph_pkg::DATA_W-1:0]            r_chk;

    logic [icph_pkg::TOTAL_W-1:0]           n_total;
    logic [icph_pkg::DATA_W+1:0]            w_fold1;
    logic [icph_pkg::DATA_W:0]              w_fold2;
    logic [icph_pkg::DATA_W:0]              w_fold3;
    logic                                   w_o_free;
    logic                                   w_t_free;
    logic                                   w_t_move;

    assign w_o_free    = !r_o_valid || o_out.ready;
    assign w_t_free    = !r_t_valid || w_o_free;
    assign w_t_move    = r_t_valid && w_o_free;
    assign o_end_ready = w_t_free;

    // Packet sum plus start value, pseudo-header constants and length
    assign n_total = {1'b0, i_end.sum}
                   + icph_pkg::TOTAL_W'(i_cfg.base_sum)
                   + (i_cfg.pseudo_enable ? icph_pkg::TOTAL_W'(i_end.bytes)
                                          : icph_pkg::TOTAL_W'(0));

    // Three folds bring any 33-bit total down to 16 bits
    assign w_fold1 = {2'd0, r_total[15:0]} + {1'b0, r_total[32:16]};
    assign w_fold2 = {1'b0, w_fold1[15:0]} + {15'd0, w_fold1[17:16]};
    assign w_fold3 = {1'b0, w_fold2[15:0]} + {16'd0, w_fold2[16]};

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (w_t_free)
                r_t_valid <= i_end_valid;
            if (w_o_free)
                r_o_valid <= r_t_valid;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (w_t_free)
            r_total <= n_total;
        if (w_t_move)
            r_chk <= ~w_fold3[15:0];
    end

    assign o_out.valid          = r_o_valid;
    assign o_out.checksum_value = r_chk;

    // A non-zero total never folds to zero
    a_nonzero_fold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_t_move && r_total != '0) |=> (r_chk != 16'hFFFF))
        else $error("non-zero total folded to zero");

    // A result only appears after a summed packet was waiting
    a_out_from_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_o_valid) |-> $past(r_t_valid))
        else $error("checksum shown without a summed packet");

endmodule

FILE: rtl/internet_checksum_pseudo_header_unit.sv
// Internet checksum unit: accepts one 16-bit word per cycle, valid/ready on
// both sides; a last word is held while the final sum stage is busy. Each word
// is registered, then added into a 32-bit end-around-carry accumulator; that
// single add sets the rate of one word per cycle. On the word marked last the
// packet sum, start value and (when enabled) pseudo-header words are added,
// folded to 16 bits and complemented; the checksum passes the packet-end, total
// and output registers and is held until taken. Registers are written over APB
// at byte address 4*i and are to be changed only while no packet is in flight.
module internet_checksum_pseudo_header_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    icph_in_if.sink                         i_in,
    icph_out_if.source                      o_out,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [icph_pkg::APB_AW-1:0]     paddr,
    input  logic [icph_pkg::APB_DW-1:0]     pwdata,
    output logic [icph_pkg::APB_DW-1:0]     prdata,
    output logic                            pready
);

    icph_pkg::t_cfg         w_cfg;
    icph_pkg::t_pkt_end     w_end;
    logic                   w_end_valid;
    logic                   w_end_ready;

    // Register file
    icph_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Word accumulator
    icph_acc u_acc (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_end_valid (w_end_valid),
        .i_end_ready (w_end_ready),
        .o_end       (w_end)
    );

    // Final sum, fold and output register
    icph_fold u_fold (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_end_valid (w_end_valid),
        .o_end_ready (w_end_ready),
        .i_end       (w_end),
        .i_cfg       (w_cfg),
        .o_out       (o_out)
    );

endmodule

FILE: tb/tb_checksum_checker.sv
// Checker for the checksum unit: tracks settings, predicts each checksum and compares.
`timescale 1ns / 100ps

module tb_checksum_checker
    import icph_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    icph_in_if                in_ch,
    icph_out_if               out_ch,
    input  logic              i_psel,
    input  logic              i_penable,
    input  logic              i_pwrite,
    input  logic              i_pready,
    input  logic [APB_AW-1:0] i_paddr,
    input  logic [APB_DW-1:0] i_pwdata,
    output int                o_fail_count,
    output int                o_checksums_due
);

    // Shadow copy of the register file
    logic               cfg_pseudo_en;
    logic [ADDR_W-1:0]  cfg_src;
    logic [ADDR_W-1:0]  cfg_dst;
    logic [PROTO_W-1:0] cfg_proto;
    logic [DATA_W-1:0]  cfg_init;

    // Packet accumulator as the block should hold it
    logic [SUM_W-1:0]   pkt_sum;
    logic [BYTES_W-1:0] pkt_bytes;

    logic [DATA_W-1:0]  expected_checksums[$];

    initial begin
        o_fail_count    = 0;
        o_checksums_due = 0;
    end

    // 32-bit add with the carry out of bit 31 fed back into bit 0
    function automatic logic [SUM_W-1:0] add_end_around(input logic [SUM_W-1:0] acc,
                                                        input logic [DATA_W-1:0] w);
        logic [SUM_W:0] t;
        t = {1'b0, acc} + {{(SUM_W - DATA_W + 1){1'b0}}, w};
        return t[SUM_W] ? t[SUM_W-1:0] + 1'b1 : t[SUM_W-1:0];
    endfunction

    // Start value, optional pseudo-header, fold to 16 bits, complement
    function automatic logic [DATA_W-1:0] packet_checksum(input logic [SUM_W-1:0] sum,
                                                          input logic [BYTES_W-1:0] bytes);
        logic [63:0] total;
        total = 64'(sum) + 64'(cfg_init);
        if (cfg_pseudo_en) begin
            total += 64'(cfg_src[31:16]) + 64'(cfg_src[15:0]);
            total += 64'(cfg_dst[31:16]) + 64'(cfg_dst[15:0]);
            total += 64'(cfg_proto) + 64'(bytes);
        end
        while ((total >> 16) != 0) begin
            total = (total & 64'hFFFF) + (total >> 16);
        end
        return ~total[DATA_W-1:0];
    endfunction

    task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                   input logic [DATA_W-1:0] want);
        $display("%0t: checksum error, %s: got %04h, want %04h", $time, what, got, want);
        o_fail_count++;
    endtask

    // Sample all channels at the rising edge; input side first, result side after
    always @(posedge i_clk) begin : watch
        logic [DATA_W-1:0] want;
        if (!i_rst_n) begin
            cfg_pseudo_en = 1'b0;
            cfg_src       = '0;
            cfg_dst       = '0;
            cfg_proto     = '0;
            cfg_init      = '0;
            pkt_sum       = '0;
            pkt_bytes     = '0;
            expected_checksums.delete();
        end else begin
            // register writes
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (t_reg_idx'(i_paddr[APB_AW-1:2]))
                    REG_PSEUDO_ENABLE: cfg_pseudo_en = i_pwdata[0];
                    REG_SRC_ADDR:      cfg_src       = i_pwdata[ADDR_W-1:0];
                    REG_DST_ADDR:      cfg_dst       = i_pwdata[ADDR_W-1:0];
                    REG_PROTOCOL:      cfg_proto     = i_pwdata[PROTO_W-1:0];
                    REG_INITIAL_SUM:   cfg_init      = i_pwdata[DATA_W-1:0];
                    default: ;
                endcase
            end

            // accepted packet word
            if (in_ch.valid && in_ch.ready) begin
                case (in_ch.byte_count)
                    BYTES_ONE: begin
                        pkt_sum   = add_end_around(pkt_sum, in_ch.data_word & HIGH_BYTE_MASK);
                        pkt_bytes = pkt_bytes + 16'd1;
                    end
                    BYTES_TWO, BYTES_WIDE: begin
                        pkt_sum   = add_end_around(pkt_sum, in_ch.data_word);
                        pkt_bytes = pkt_bytes + 16'd2;
                    end
                    default: ;
                endcase
                if (in_ch.last) begin
                    expected_checksums.push_back(packet_checksum(pkt_sum, pkt_bytes));
                    pkt_sum   = '0;
                    pkt_bytes = '0;
                end
            end

            // accepted checksum word
            if (out_ch.valid && out_ch.ready) begin
                if (expected_checksums.size() == 0) begin
                    report_mismatch("checksum with no packet pending", out_ch.checksum_value,
                                    '0);
                end else begin
                    want = expected_checksums.pop_front();
                    if (out_ch.checksum_value !== want) begin
                        report_mismatch("checksum_value", out_ch.checksum_value, want);
                    end
                end
            end
        end
        o_checksums_due <= expected_checksums.size();
    end

endmodule

FILE: tb/tb_top.sv
// Testbench top for the checksum unit: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_top;
    import icph_pkg::*;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    int fail_count;
    int checksums_due;
    int send_idle_pct = 24;
    int recv_idle_pct = 67;
    int words_sent    = 0;

    icph_in_if  word_ch ();
    icph_out_if sum_ch ();

    internet_checksum_pseudo_header_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (word_ch),
        .o_out   (sum_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    tb_checksum_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .in_ch           (word_ch),
        .out_ch          (sum_ch),
        .i_psel          (psel),
        .i_penable       (penable),
        .i_pwrite        (pwrite),
        .i_pready        (pready),
        .i_paddr         (paddr),
        .i_pwdata        (pwdata),
        .o_fail_count    (fail_count),
        .o_checksums_due (checksums_due)
    );

    // 100 MHz clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Result side back-pressure
    initial begin
        sum_ch.ready <= 1'b0;
        forever begin
            @(negedge i_clk);
            sum_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Hang guard
    initial begin
        #10_000_000;
        $display("FAILURE");
        $finish;
    end

    // Two-phase APB write; the register takes the value on the access edge
    task automatic apb_write(input t_reg_idx idx, input logic [APB_DW-1:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_checksum_config(input logic pseudo_en, input logic [ADDR_W-1:0] src,
                                       input logic [ADDR_W-1:0] dst,
                                       input logic [PROTO_W-1:0] proto,
                                       input logic [DATA_W-1:0] init);
        apb_write(REG_PSEUDO_ENABLE, {31'd0, pseudo_en});
        apb_write(REG_SRC_ADDR, src);
        apb_write(REG_DST_ADDR, dst);
        apb_write(REG_PROTOCOL, {24'd0, proto});
        apb_write(REG_INITIAL_SUM, {16'd0, init});
    endtask

    // Offer one word, with random idle cycles ahead of it, and wait until taken
    task automatic push_word(input logic [DATA_W-1:0] w, input logic [COUNT_W-1:0] cnt,
                             input logic lst);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            word_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        word_ch.valid      <= 1'b1;
        word_ch.data_word  <= w;
        word_ch.byte_count <= cnt;
        word_ch.last       <= lst;
        @(posedge i_clk);
        while (!word_ch.ready) @(posedge i_clk);
        words_sent++;
    endtask

    // Drop valid and let every pending checksum drain before touching registers
    task automatic wait_until_idle();
        @(negedge i_clk);
        word_ch.valid <= 1'b0;
        while (checksums_due != 0) @(negedge i_clk);
        repeat (6) @(negedge i_clk);
    endtask

    // Mostly short packets, now and then a longer one; odd byte counts sprinkled in
    task automatic send_random_packet();
        int                 len;
        int                 pick;
        logic [COUNT_W-1:0] cnt;
        logic [DATA_W-1:0]  w;
        len = ($urandom_range(9) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 1);
        for (int k = 0; k < len; k++) begin
            pick = $urandom_range(99);
            if (pick < 6)
                cnt = BYTES_NONE;
            else if (pick < 10)
                cnt = BYTES_WIDE;
            else if (pick < 22)
                cnt = BYTES_ONE;
            else
                cnt = BYTES_TWO;
            pick = $urandom_range(15);
            if (pick == 0)
                w = '0;
            else if (pick == 1)
                w = '1;
            else
                w = DATA_W'($urandom);
            push_word(w, cnt, k == len - 1);
        end
    endtask

    task automatic send_random_block(input int n_words);
        int stop_at;
        stop_at = words_sent + n_words;
        set_checksum_config(1'($urandom_range(1)), $urandom, $urandom,
                            PROTO_W'($urandom), DATA_W'($urandom));
        while (words_sent < stop_at) send_random_packet();
        wait_until_idle();
    endtask

    initial begin
        word_ch.valid      <= 1'b0;
        word_ch.data_word  <= '0;
        word_ch.byte_count <= BYTES_TWO;
        word_ch.last       <= 1'b0;
        psel               <= 1'b0;
        penable            <= 1'b0;
        pwrite             <= 1'b0;
        paddr              <= '0;
        pwdata             <= '0;
        i_rst_n            <= 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reset settings, plain checksum
        push_word(16'h0000, BYTES_TWO, 1'b1);    // zero sum gives all ones
        push_word(16'hFFFF, BYTES_TWO, 1'b1);
        push_word(16'hABCD, BYTES_ONE, 1'b0);    // single byte mid-packet
        push_word(16'h12FF, BYTES_ONE, 1'b1);
        push_word(16'hFFFF, BYTES_NONE, 1'b0);   // empty word adds nothing
        push_word(16'h1234, BYTES_WIDE, 1'b1);   // count three taken as two
        push_word(16'hFFFF, BYTES_NONE, 1'b1);   // packet of nothing
        wait_until_idle();

        // Directed: every register at its top value
        set_checksum_config(1'b1, '1, '1, '1, '1);
        push_word(16'hFFFF, BYTES_TWO, 1'b0);
        push_word(16'hFFFF, BYTES_TWO, 1'b0);
        push_word(16'h0001, BYTES_ONE, 1'b1);
        push_word(16'h0000, BYTES_NONE, 1'b1);
        push_word(16'h8000, BYTES_TWO, 1'b0);
        push_word(16'h7FFF, BYTES_TWO, 1'b1);
        wait_until_idle();

        // Directed: pseudo-header on, everything else zero
        set_checksum_config(1'b1, '0, '0, '0, '0);
        push_word(16'h0000, BYTES_TWO, 1'b1);
        push_word(16'hFFFF, BYTES_ONE, 1'b1);
        wait_until_idle();

        // Random, sender idles lightly and receiver heavily
        send_random_block(300);
        send_random_block(300);

        // Random, the other way round
        send_idle_pct = 67;
        recv_idle_pct = 24;
        send_random_block(300);
        send_random_block(300);

        // Random, no idling
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_random_block(300);
        send_random_block(300);

        @(negedge i_clk);
        word_ch.valid <= 1'b0;

        // Drain, then settle
        for (int k = 0; k < 5000 && checksums_due != 0; k++) @(negedge i_clk);
        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && checksums_due == 0) begin
            $display("SUCCESS");
        end else begin
            if (checksums_due != 0)
                $display("%0d expected checksums never arrived", checksums_due);
            $display("FAILURE");
        end
        $finish;
    end

endmodule
